// ===== hw/rtl/dvc_pkg.sv =====
// Shared types, widths, codes and reset values for the drag velocity and
// coasting block. Used by dvc_div, dvc_sqrt and drag_velocity_and_coasting; depends on nothing.
package dvc_pkg;

  // History ring
  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  // Field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 16;
  localparam int TS_W   = 32;
  localparam int DMS_W  = 10;
  localparam int DLT_W  = 16;
  localparam int VEL_W  = 24;
  localparam int HLEN_W = 5;
  localparam int CFG_W  = 23;
  localparam int CFG_AW = 2;
  localparam int IN_W   = 80;
  localparam int OUT_W  = 80;
  localparam int RAM_W  = 2 * POS_W + TS_W;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_HIST_LEN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_THRESH   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FRICTION = 2'd2;

  // Register reset values
  localparam logic [HLEN_W-1:0] HLEN_RST = 5'd5;
  localparam logic [CFG_W-1:0]  THR_RST  = 23'd3200;
  localparam logic [CFG_W-1:0]  FRIC_RST = 23'd16000;

  localparam int MS_PER_S = 1000;

  // Shared multiplier
  localparam int MUL_W = 24;
  localparam int DEC_W = CFG_W + DMS_W;

  // Serial divider: quotient bits, divisor bits, dividend bits
  localparam int DIV_QW = 27;
  localparam int DIV_DW = 34;
  localparam int DIV_NW = DIV_QW + DIV_DW;
  localparam int DIV_CW = $clog2(DIV_QW + 1);

  // Serial square root
  localparam int SQ_NW = 48;
  localparam int SQ_RW = SQ_NW / 2;
  localparam int SQ_CW = $clog2(SQ_RW + 1);

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_MOVE  = 2'd1,
    OP_END   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_VEL_CHK,
    S_VEL_RD,
    S_VEL_DIV,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_TH,
    S_CMP,
    S_TK_DEC,
    S_TK_SQX,
    S_TK_SQY,
    S_TK_SQS,
    S_TK_SQW,
    S_TK_CHK,
    S_TK_P0,
    S_TK_P1,
    S_TK_P2,
    S_TK_P3,
    S_TK_P4,
    S_TK_QW,
    S_TK_D0,
    S_TK_D1,
    S_TK_D2,
    S_TK_DW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SQ_NW-1:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic             done;
    logic [SQ_RW-1:0] root;
  } sq_rsp_t;

endpackage

// ===== hw/rtl/dvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the pointer history ring; no dependencies.
module dvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dvc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dvc_pkg; the caller keeps dividend / divisor below 2**DIV_QW.
module dvc_div (
  input  logic             clk,
  input  logic             rst,
  input  dvc_pkg::div_req_t req,
  output dvc_pkg::div_rsp_t rsp
);

  logic [dvc_pkg::DIV_DW-1:0] rem;
  logic [dvc_pkg::DIV_DW-1:0] dsr;
  logic [dvc_pkg::DIV_QW-1:0] low;
  logic [dvc_pkg::DIV_CW-1:0] cnt;
  logic                       done;
  logic [dvc_pkg::DIV_DW:0]   shifted;
  logic [dvc_pkg::DIV_DW:0]   diff;
  logic                       ge;

  assign shifted = {rem, low[dvc_pkg::DIV_QW-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= dvc_pkg::DIV_CW'(dvc_pkg::DIV_QW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == dvc_pkg::DIV_CW'(1));
      end
    end
  end

  // Quotient bits shift into the low word as dividend bits leave it
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[dvc_pkg::DIV_NW-1:dvc_pkg::DIV_QW];
      low <= req.dividend[dvc_pkg::DIV_QW-1:0];
      dsr <= req.divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[dvc_pkg::DIV_DW-1:0] : shifted[dvc_pkg::DIV_DW-1:0];
      low <= {low[dvc_pkg::DIV_QW-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = low;

endmodule

// ===== hw/rtl/dvc_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on dvc_pkg; returns floor(sqrt(radicand)).
module dvc_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  dvc_pkg::sq_req_t req,
  output dvc_pkg::sq_rsp_t rsp
);

  logic [dvc_pkg::SQ_NW-1:0] rad;
  logic [dvc_pkg::SQ_RW+1:0] rem;
  logic [dvc_pkg::SQ_RW-1:0] root;
  logic [dvc_pkg::SQ_CW-1:0] cnt;
  logic                      done;
  logic [dvc_pkg::SQ_RW+3:0] cur;
  logic [dvc_pkg::SQ_RW+3:0] trial;
  logic                      ge;

  assign cur   = {rem, rad[dvc_pkg::SQ_NW-1:dvc_pkg::SQ_NW-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= dvc_pkg::SQ_CW'(dvc_pkg::SQ_RW);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == dvc_pkg::SQ_CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= {rad[dvc_pkg::SQ_NW-3:0], 2'b00};
      rem  <= ge ? (dvc_pkg::SQ_RW+2)'(cur - trial) : cur[dvc_pkg::SQ_RW+1:0];
      root <= {root[dvc_pkg::SQ_RW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== hw/rtl/drag_velocity_and_coasting.sv =====
// Drag velocity and coasting: pointer start/move/end/tick in, one result out.
// The serial divider runs at most once per move/end and at most twice per tick;
// a tick that coasts also runs the serial square root. One item at a time; the
// output register lets the next item in while a result waits. rst (synchronous)
// clears control state and loads register defaults.
module drag_velocity_and_coasting (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_x[15:0], pos_y[31:16], timestamp_ms[63:32], delta_ms[73:64], zero pad
  input  logic [dvc_pkg::IN_W-1:0]    s_tdata,
  // operation[1:0]
  input  logic [dvc_pkg::OP_W-1:0]    s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // delta_x[15:0], delta_y[31:16], vel_x[55:32], vel_y[79:56]
  output logic [dvc_pkg::OUT_W-1:0]   m_tdata,
  // coasting[0], tick_moved[1]
  output logic [1:0]                  m_tuser,
  input  logic                        cfg_we,
  input  logic [dvc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [dvc_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IW = dvc_pkg::IDX_W;
  localparam int CW = dvc_pkg::CNT_W;

  function automatic logic [23:0] abs24(input logic [23:0] v);
    abs24 = v[23] ? 24'(-v) : v;
  endfunction

  function automatic logic [33:0] mul1000(input logic [23:0] v);
    mul1000 = {v, 10'b0} - {6'b0, v, 4'b0} - {7'b0, v, 3'b0};
  endfunction

  function automatic logic [23:0] sat_vel(input logic neg, input logic [26:0] q);
    if (!neg) begin
      sat_vel = (q > 27'd8388607) ? 24'h7FFFFF : q[23:0];
    end else begin
      sat_vel = (q > 27'd8388608) ? 24'h800000 : 24'(-q[23:0]);
    end
  endfunction

  function automatic logic [15:0] sat_dlt(input logic neg, input logic [26:0] q);
    if (!neg) begin
      sat_dlt = (q > 27'd32767) ? 16'h7FFF : q[15:0];
    end else begin
      sat_dlt = (q > 27'd32768) ? 16'h8000 : 16'(-q[15:0]);
    end
  endfunction

  // Configuration
  logic [dvc_pkg::HLEN_W-1:0] hist_len;
  logic [dvc_pkg::CFG_W-1:0]  thresh;
  logic [dvc_pkg::CFG_W-1:0]  fric;

  dvc_pkg::state_t state, state_next;

  // Latched item
  dvc_pkg::op_t              op_r;
  logic [dvc_pkg::POS_W-1:0] x_r, y_r;
  logic [dvc_pkg::TS_W-1:0]  ts_r;
  logic [dvc_pkg::DMS_W-1:0] dms_r;

  // Tracking state
  logic [IW-1:0]             hist_head;
  logic [CW-1:0]             hist_count;
  logic [dvc_pkg::POS_W-1:0] new_x, new_y, last_x, last_y;
  logic [dvc_pkg::TS_W-1:0]  new_t;
  logic [dvc_pkg::DLT_W-1:0] dlt_x, dlt_y;
  logic [dvc_pkg::VEL_W-1:0] vel_x, vel_y, mom_x, mom_y;
  logic                      coast, moved;

  // Arithmetic scratch
  logic [dvc_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*dvc_pkg::MUL_W-1:0] prod, acc, pa;
  logic [56:0]                 pxa;
  logic [dvc_pkg::DEC_W-1:0]   dec_r;
  logic [dvc_pkg::SQ_RW-1:0]   mag;
  logic [33:0]                 mag1000;
  logic                        sgn_x, sgn_y;

  // History RAM
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr, oldest;
  logic [dvc_pkg::RAM_W-1:0] ram_rdata;

  dvc_pkg::div_req_t dvx_req, dvy_req;
  dvc_pkg::div_rsp_t dvx_rsp, dvy_rsp;
  dvc_pkg::sq_req_t  sq_req;
  dvc_pkg::sq_rsp_t  sq_rsp;

  logic              accept, out_free;
  logic [CW-1:0]     eff_len, cnt_inc, cnt_move;
  logic [IW-1:0]     head_inc;
  logic [IW:0]       old_sum;
  logic [16:0]       mdx, mdy, vdx, vdy;
  logic [dvc_pkg::POS_W-1:0] old_x, old_y;
  logic [dvc_pkg::TS_W-1:0]  old_t;
  logic              td_pos, stop_coast;
  logic [23:0]       am_x, am_y, nm_x, nm_y;
  logic [26:0]       qx, qy;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign eff_len = (hist_len == '0) ? CW'(1) :
                   ((32'(hist_len) > dvc_pkg::HIST_DEPTH) ? CW'(dvc_pkg::HIST_DEPTH)
                                                          : CW'(hist_len));
  assign cnt_inc  = (hist_count == CW'(dvc_pkg::HIST_DEPTH)) ? hist_count
                                                             : hist_count + 1'b1;
  assign cnt_move = (cnt_inc > eff_len) ? eff_len : cnt_inc;
  assign head_inc = (hist_head == IW'(dvc_pkg::HIST_DEPTH - 1)) ? '0 : hist_head + 1'b1;
  assign old_sum  = (IW+1)'(hist_head) + (IW+1)'(dvc_pkg::HIST_DEPTH)
                  - (IW+1)'(hist_count);
  assign oldest   = (old_sum >= (IW+1)'(dvc_pkg::HIST_DEPTH))
                  ? IW'(old_sum - (IW+1)'(dvc_pkg::HIST_DEPTH)) : IW'(old_sum);

  assign mdx = {x_r[15], x_r} - {last_x[15], last_x};
  assign mdy = {y_r[15], y_r} - {last_y[15], last_y};

  assign old_x  = ram_rdata[15:0];
  assign old_y  = ram_rdata[31:16];
  assign old_t  = ram_rdata[63:32];
  assign vdx    = {new_x[15], new_x} - {old_x[15], old_x};
  assign vdy    = {new_y[15], new_y} - {old_y[15], old_y};
  assign td_pos = new_t > old_t;

  assign mag1000    = mul1000(mag);
  assign stop_coast = mag1000 < 34'(dec_r);
  assign am_x       = abs24(mom_x);
  assign am_y       = abs24(mom_y);
  // A zero magnitude only gets here with zero deceleration: subtract nothing
  assign qx         = (mag == '0) ? '0 : dvx_rsp.quotient;
  assign qy         = (mag == '0) ? '0 : dvy_rsp.quotient;
  assign nm_x       = am_x - qx[23:0];
  assign nm_y       = am_y - qy[23:0];

  dvc_ram #(
    .WIDTH(dvc_pkg::RAM_W),
    .DEPTH(dvc_pkg::HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({ts_r, y_r, x_r}),
    .raddr(oldest),
    .rdata(ram_rdata)
  );

  dvc_div u_div_x (.clk(clk), .rst(rst), .req(dvx_req), .rsp(dvx_rsp));
  dvc_div u_div_y (.clk(clk), .rst(rst), .req(dvy_req), .rsp(dvy_rsp));
  dvc_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .rsp(sq_rsp));

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dvc_pkg::S_IDLE:     if (s_tvalid) state_next = dvc_pkg::S_DISPATCH;
      dvc_pkg::S_DISPATCH: begin
        case (op_r)
          dvc_pkg::OP_START: state_next = dvc_pkg::S_DONE;
          dvc_pkg::OP_MOVE:  state_next = dvc_pkg::S_VEL_CHK;
          dvc_pkg::OP_END:   state_next = dvc_pkg::S_VEL_CHK;
          default:           state_next = coast ? dvc_pkg::S_TK_DEC : dvc_pkg::S_DONE;
        endcase
      end
      dvc_pkg::S_VEL_CHK: begin
        if (hist_count >= CW'(2)) begin
          state_next = dvc_pkg::S_VEL_RD;
        end else begin
          state_next = (op_r == dvc_pkg::OP_END) ? dvc_pkg::S_SQ_X : dvc_pkg::S_DONE;
        end
      end
      dvc_pkg::S_VEL_RD: begin
        if (td_pos) begin
          state_next = dvc_pkg::S_VEL_DIV;
        end else begin
          state_next = (op_r == dvc_pkg::OP_END) ? dvc_pkg::S_SQ_X : dvc_pkg::S_DONE;
        end
      end
      dvc_pkg::S_VEL_DIV: begin
        if (dvx_rsp.done) begin
          state_next = (op_r == dvc_pkg::OP_END) ? dvc_pkg::S_SQ_X : dvc_pkg::S_DONE;
        end
      end
      dvc_pkg::S_SQ_X:   state_next = dvc_pkg::S_SQ_Y;
      dvc_pkg::S_SQ_Y:   state_next = dvc_pkg::S_SQ_TH;
      dvc_pkg::S_SQ_TH:  state_next = dvc_pkg::S_CMP;
      dvc_pkg::S_CMP:    state_next = dvc_pkg::S_DONE;
      dvc_pkg::S_TK_DEC: state_next = dvc_pkg::S_TK_SQX;
      dvc_pkg::S_TK_SQX: state_next = dvc_pkg::S_TK_SQY;
      dvc_pkg::S_TK_SQY: state_next = dvc_pkg::S_TK_SQS;
      dvc_pkg::S_TK_SQS: state_next = dvc_pkg::S_TK_SQW;
      dvc_pkg::S_TK_SQW: if (sq_rsp.done) state_next = dvc_pkg::S_TK_CHK;
      dvc_pkg::S_TK_CHK: state_next = stop_coast ? dvc_pkg::S_DONE : dvc_pkg::S_TK_P0;
      dvc_pkg::S_TK_P0:  state_next = dvc_pkg::S_TK_P1;
      dvc_pkg::S_TK_P1:  state_next = dvc_pkg::S_TK_P2;
      dvc_pkg::S_TK_P2:  state_next = dvc_pkg::S_TK_P3;
      dvc_pkg::S_TK_P3:  state_next = dvc_pkg::S_TK_P4;
      dvc_pkg::S_TK_P4:  state_next = dvc_pkg::S_TK_QW;
      dvc_pkg::S_TK_QW:  if (dvx_rsp.done) state_next = dvc_pkg::S_TK_D0;
      dvc_pkg::S_TK_D0:  state_next = dvc_pkg::S_TK_D1;
      dvc_pkg::S_TK_D1:  state_next = dvc_pkg::S_TK_D2;
      dvc_pkg::S_TK_D2:  state_next = dvc_pkg::S_TK_DW;
      dvc_pkg::S_TK_DW:  if (dvx_rsp.done) state_next = dvc_pkg::S_DONE;
      dvc_pkg::S_DONE:   if (out_free) state_next = dvc_pkg::S_IDLE;
      default:           state_next = dvc_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshake, RAM write, multiplier operands, unit starts
  always_comb begin
    s_tready          = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = hist_head;
    mul_a             = '0;
    mul_b             = '0;
    dvx_req.start     = 1'b0;
    dvx_req.dividend  = '0;
    dvx_req.divisor   = '0;
    dvy_req.start     = 1'b0;
    dvy_req.dividend  = '0;
    dvy_req.divisor   = '0;
    sq_req.start      = 1'b0;
    sq_req.radicand   = acc + prod;
    case (state)
      dvc_pkg::S_IDLE: s_tready = 1'b1;
      dvc_pkg::S_DISPATCH: begin
        if (op_r == dvc_pkg::OP_START) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (op_r == dvc_pkg::OP_MOVE) begin
          ram_we = 1'b1;
        end
      end
      dvc_pkg::S_VEL_RD: begin
        dvx_req.start    = td_pos;
        dvy_req.start    = td_pos;
        dvx_req.dividend = dvc_pkg::DIV_NW'(mul1000(24'(vdx[16] ? 17'(-vdx) : vdx)));
        dvy_req.dividend = dvc_pkg::DIV_NW'(mul1000(24'(vdy[16] ? 17'(-vdy) : vdy)));
        dvx_req.divisor  = dvc_pkg::DIV_DW'(new_t - old_t);
        dvy_req.divisor  = dvc_pkg::DIV_DW'(new_t - old_t);
      end
      dvc_pkg::S_SQ_X: begin
        mul_a = abs24(vel_x);
        mul_b = abs24(vel_x);
      end
      dvc_pkg::S_SQ_Y: begin
        mul_a = abs24(vel_y);
        mul_b = abs24(vel_y);
      end
      dvc_pkg::S_SQ_TH: begin
        mul_a = dvc_pkg::MUL_W'(thresh);
        mul_b = dvc_pkg::MUL_W'(thresh);
      end
      dvc_pkg::S_TK_DEC: begin
        mul_a = dvc_pkg::MUL_W'(fric);
        mul_b = dvc_pkg::MUL_W'(dms_r);
      end
      dvc_pkg::S_TK_SQX: begin
        mul_a = am_x;
        mul_b = am_x;
      end
      dvc_pkg::S_TK_SQY: begin
        mul_a = am_y;
        mul_b = am_y;
      end
      dvc_pkg::S_TK_SQS: sq_req.start = 1'b1;
      dvc_pkg::S_TK_P0: begin
        mul_a = am_x;
        mul_b = dec_r[23:0];
      end
      dvc_pkg::S_TK_P1: begin
        mul_a = am_x;
        mul_b = dvc_pkg::MUL_W'(dec_r[dvc_pkg::DEC_W-1:24]);
      end
      dvc_pkg::S_TK_P2: begin
        mul_a = am_y;
        mul_b = dec_r[23:0];
      end
      dvc_pkg::S_TK_P3: begin
        mul_a = am_y;
        mul_b = dvc_pkg::MUL_W'(dec_r[dvc_pkg::DEC_W-1:24]);
      end
      dvc_pkg::S_TK_P4: begin
        dvx_req.start    = 1'b1;
        dvy_req.start    = 1'b1;
        dvx_req.dividend = dvc_pkg::DIV_NW'(pxa);
        dvy_req.dividend = dvc_pkg::DIV_NW'(57'(pa) + {prod[32:0], 24'b0});
        dvx_req.divisor  = mag1000;
        dvy_req.divisor  = mag1000;
      end
      dvc_pkg::S_TK_D0: begin
        mul_a = am_x;
        mul_b = dvc_pkg::MUL_W'(dms_r);
      end
      dvc_pkg::S_TK_D1: begin
        mul_a = am_y;
        mul_b = dvc_pkg::MUL_W'(dms_r);
      end
      dvc_pkg::S_TK_D2: begin
        dvx_req.start    = 1'b1;
        dvy_req.start    = 1'b1;
        dvx_req.dividend = dvc_pkg::DIV_NW'(pa);
        dvy_req.dividend = dvc_pkg::DIV_NW'(prod);
        dvx_req.divisor  = dvc_pkg::DIV_DW'(dvc_pkg::MS_PER_S);
        dvy_req.divisor  = dvc_pkg::DIV_DW'(dvc_pkg::MS_PER_S);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= dvc_pkg::HLEN_RST;
      thresh   <= dvc_pkg::THR_RST;
      fric     <= dvc_pkg::FRIC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dvc_pkg::CFG_HIST_LEN: hist_len <= cfg_data[dvc_pkg::HLEN_W-1:0];
        dvc_pkg::CFG_THRESH:   thresh   <= cfg_data;
        dvc_pkg::CFG_FRICTION: fric     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item payload and scratch registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= dvc_pkg::op_t'(s_tuser);
      x_r   <= s_tdata[15:0];
      y_r   <= s_tdata[31:16];
      ts_r  <= s_tdata[63:32];
      dms_r <= s_tdata[73:64];
    end
    case (state)
      dvc_pkg::S_DISPATCH: begin
        if (op_r == dvc_pkg::OP_START || op_r == dvc_pkg::OP_MOVE) begin
          new_x <= x_r;
          new_y <= y_r;
          new_t <= ts_r;
        end
      end
      dvc_pkg::S_VEL_RD: begin
        sgn_x <= vdx[16];
        sgn_y <= vdy[16];
      end
      dvc_pkg::S_SQ_Y:   acc <= prod;
      dvc_pkg::S_SQ_TH:  acc <= acc + prod;
      dvc_pkg::S_TK_SQX: dec_r <= prod[dvc_pkg::DEC_W-1:0];
      dvc_pkg::S_TK_SQY: acc <= prod;
      dvc_pkg::S_TK_SQW: if (sq_rsp.done) mag <= sq_rsp.root;
      dvc_pkg::S_TK_P1:  pa <= prod;
      dvc_pkg::S_TK_P2:  pxa <= 57'(pa) + {prod[32:0], 24'b0};
      dvc_pkg::S_TK_P3:  pa <= prod;
      dvc_pkg::S_TK_QW: begin
        sgn_x <= mom_x[23];
        sgn_y <= mom_y[23];
      end
      dvc_pkg::S_TK_D1:  pa <= prod;
      default: ;
    endcase
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_head  <= '0;
      hist_count <= '0;
      last_x     <= '0;
      last_y     <= '0;
      dlt_x      <= '0;
      dlt_y      <= '0;
      vel_x      <= '0;
      vel_y      <= '0;
      mom_x      <= '0;
      mom_y      <= '0;
      coast      <= 1'b0;
      moved      <= 1'b0;
    end else begin
      case (state)
        dvc_pkg::S_DISPATCH: begin
          moved <= 1'b0;
          if (op_r == dvc_pkg::OP_START) begin
            hist_head  <= IW'(1);
            hist_count <= CW'(1);
            last_x     <= x_r;
            last_y     <= y_r;
            dlt_x      <= '0;
            dlt_y      <= '0;
            vel_x      <= '0;
            vel_y      <= '0;
            coast      <= 1'b0;
          end else if (op_r == dvc_pkg::OP_MOVE) begin
            dlt_x      <= (!mdx[16] && mdx[15]) ? 16'h7FFF :
                          ((mdx[16] && !mdx[15]) ? 16'h8000 : mdx[15:0]);
            dlt_y      <= (!mdy[16] && mdy[15]) ? 16'h7FFF :
                          ((mdy[16] && !mdy[15]) ? 16'h8000 : mdy[15:0]);
            last_x     <= x_r;
            last_y     <= y_r;
            hist_head  <= head_inc;
            hist_count <= cnt_move;
          end
        end
        dvc_pkg::S_VEL_CHK: begin
          vel_x <= '0;
          vel_y <= '0;
        end
        dvc_pkg::S_VEL_DIV: begin
          if (dvx_rsp.done) begin
            vel_x <= sat_vel(sgn_x, dvx_rsp.quotient);
            vel_y <= sat_vel(sgn_y, dvy_rsp.quotient);
          end
        end
        dvc_pkg::S_CMP: begin
          // Release speed squared against threshold squared
          if (acc > prod) begin
            mom_x <= vel_x;
            mom_y <= vel_y;
            coast <= 1'b1;
          end
          hist_head  <= '0;
          hist_count <= '0;
        end
        dvc_pkg::S_TK_CHK: begin
          if (stop_coast) begin
            mom_x <= '0;
            mom_y <= '0;
            coast <= 1'b0;
          end
        end
        dvc_pkg::S_TK_QW: begin
          if (dvx_rsp.done) begin
            mom_x <= mom_x[23] ? 24'(-nm_x) : nm_x;
            mom_y <= mom_y[23] ? 24'(-nm_y) : nm_y;
          end
        end
        dvc_pkg::S_TK_DW: begin
          if (dvx_rsp.done) begin
            dlt_x <= sat_dlt(mom_x[23], dvx_rsp.quotient);
            dlt_y <= sat_dlt(mom_y[23], dvy_rsp.quotient);
            moved <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == dvc_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dvc_pkg::S_DONE && out_free) begin
      m_tdata <= {vel_y, vel_x, dlt_y, dlt_x};
      m_tuser <= {moved, coast};
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer taken while an item is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= CW'(dvc_pkg::HIST_DEPTH))
    else $error("history count above ring depth");

  a_coast_start: assert property (@(posedge clk) disable iff (rst)
    $rose(coast) |-> $past(state) == dvc_pkg::S_CMP)
    else $error("coasting started outside release compare");

  a_lanes_align: assert property (@(posedge clk) disable iff (rst)
    dvx_rsp.done == dvy_rsp.done)
    else $error("axis dividers out of step");
`endif

endmodule
